// ===== rtl/lbp_histogram_3x3_assert.svh =====
// Assertion helpers shared by the histogram RTL.
// LBPH_ASSERT checks a property on every rising clock edge outside reset.
// LBPH_ASSERT_NEVER checks that an expression is never true outside reset.
`ifndef LBP_HISTOGRAM_3X3_ASSERT_SVH
`define LBP_HISTOGRAM_3X3_ASSERT_SVH
`ifndef SYNTH
`define LBPH_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lbph assertion failed");
`define LBPH_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("lbph assertion failed");
`else
`define LBPH_ASSERT(label, clk, rst, prop)
`define LBPH_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// ===== rtl/lbph_pkg.sv =====
`timescale 1ns / 1ps

package lbph_pkg;

   localparam int CFG_W     = 11;
   localparam int CSR_IDX_W = 2;
   localparam int PIX_W     = 8;
   localparam int NUM_BINS  = 256;
   localparam int BIN_W     = $clog2(NUM_BINS);
   localparam int CODE_W    = 8;
   localparam int COUNT_W   = 20;
   localparam int ROW_LIMIT = 1024;
   localparam int ROW_W     = $clog2(ROW_LIMIT);
   localparam int ROWS_W    = $clog2(ROW_LIMIT + 1);
   localparam int MIN_DIM   = 3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [CFG_W-1:0]   DIM_RESET = CFG_W'(1024);

   // Result queue between the counter stage and the output port.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_LVL_W = $clog2(RSP_DEPTH + 1);

   // Request kinds.
   localparam logic [1:0] REQ_PIXEL = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_COLS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_ROWS = CSR_IDX_W'(1);

   typedef struct packed {
      logic [1:0]       req_type;
      logic [PIX_W-1:0] pixel;
      logic [BIN_W-1:0] bin;
   } lbph_req_type;

   typedef struct packed {
      logic               code_valid;
      logic [CODE_W-1:0]  lbp_code;
      logic [COUNT_W-1:0] bin_count;
   } lbph_rsp_type;

   typedef struct packed {
      logic             restart;
      logic [CFG_W-1:0] image_cols;
      logic [CFG_W-1:0] image_rows;
   } lbph_cfg_type;

   // Window stage to counter stage.
   typedef struct packed {
      logic              valid;
      logic [1:0]        kind;
      logic              hit;
      logic [CODE_W-1:0] code;
      logic [BIN_W-1:0]  bin;
   } lbph_stage_type;

endpackage

// ===== rtl/lbph_window.sv =====
`timescale 1ns / 1ps

module lbph_window #(
   parameter int MAX_COLS = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_accept,
   input  lbph_pkg::lbph_req_type   req_data,
   input  lbph_pkg::lbph_cfg_type   cfg,
   output lbph_pkg::lbph_stage_type stage
);
   import lbph_pkg::*;

   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int COLS_W = $clog2(MAX_COLS + 1);
   localparam int CMP_W  = (COLS_W > CFG_W) ? COLS_W : CFG_W;
   localparam logic [CMP_W-1:0]  MAX_COLS_EXT  = CMP_W'(MAX_COLS);
   localparam logic [CMP_W-1:0]  MIN_COLS_EXT  = CMP_W'(MIN_DIM);
   localparam logic [ROWS_W-1:0] MIN_ROWS_EXT  = ROWS_W'(MIN_DIM);
   localparam logic [ROWS_W-1:0] ROW_LIMIT_EXT = ROWS_W'(ROW_LIMIT);

   logic [CMP_W-1:0]  cols_ext;
   logic [COLS_W-1:0] cols_lim;
   logic [ROWS_W-1:0] rows_ext;
   logic [ROWS_W-1:0] rows_lim;

   logic [COL_W-1:0]  column_ff, column_in, col_cur;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              last_col, last_row, interior;

   logic              s1_valid_ff;
   lbph_req_type      s1_req_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic              s1_interior_ff;
   logic              s1_write, s1_clear;

   logic [PIX_W-1:0]  upper_mem [MAX_COLS];
   logic [PIX_W-1:0]  lower_mem [MAX_COLS];
   logic [PIX_W-1:0]  upper_rd_ff, lower_rd_ff;

   logic [PIX_W-1:0]  window_ff [3][3];
   logic [PIX_W-1:0]  window_in [3][3];
   logic [PIX_W-1:0]  nb [8];
   logic [PIX_W-1:0]  centre;
   logic [CODE_W-1:0] code;

   // Effective frame size, saturated into the supported range.
   always_comb begin
      cols_ext = CMP_W'(cfg.image_cols);
      rows_ext = ROWS_W'(cfg.image_rows);
      if (cols_ext < MIN_COLS_EXT) begin
         cols_lim = COLS_W'(MIN_DIM);
      end else if (cols_ext > MAX_COLS_EXT) begin
         cols_lim = COLS_W'(MAX_COLS);
      end else begin
         cols_lim = COLS_W'(cols_ext);
      end
      if (rows_ext < MIN_ROWS_EXT) begin
         rows_lim = MIN_ROWS_EXT;
      end else if (rows_ext > ROW_LIMIT_EXT) begin
         rows_lim = ROW_LIMIT_EXT;
      end else begin
         rows_lim = rows_ext;
      end
   end

   // Raster position of the arriving pixel.
   always_comb begin
      col_cur  = (COLS_W'(column_ff) >= cols_lim) ? '0 : column_ff;
      last_col = (COLS_W'(col_cur) + COLS_W'(1)) >= cols_lim;
      last_row = (ROWS_W'(row_ff) + ROWS_W'(1)) >= rows_lim;
      interior = (row_ff >= ROW_W'(2)) && (col_cur >= COL_W'(2));

      column_in = column_ff;
      row_in    = row_ff;
      if (cfg.restart) begin
         column_in = '0;
         row_in    = '0;
      end else if (req_accept) begin
         case (req_data.req_type)
            REQ_PIXEL: begin
               if (last_col) begin
                  column_in = '0;
                  row_in    = last_row ? '0 : row_ff + ROW_W'(1);
               end else begin
                  column_in = col_cur + COL_W'(1);
               end
            end
            REQ_CLEAR: begin
               column_in = '0;
               row_in    = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff   <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         column_ff   <= column_in;
         row_ff      <= row_in;
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff      <= req_data;
         s1_col_ff      <= col_cur;
         s1_interior_ff <= interior;
      end
   end

   assign s1_write = s1_valid_ff && (s1_req_ff.req_type == REQ_PIXEL);
   assign s1_clear = s1_valid_ff && (s1_req_ff.req_type == REQ_CLEAR);

   // Line stores: read at the arriving column, written back in the next cycle.
   always_ff @(posedge clock) begin
      upper_rd_ff <= upper_mem[col_cur];
      if (s1_write) begin
         upper_mem[s1_col_ff] <= lower_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      lower_rd_ff <= lower_mem[col_cur];
      if (s1_write) begin
         lower_mem[s1_col_ff] <= s1_req_ff.pixel;
      end
   end

   // Shifted window with the new right-hand column, and its pattern code.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         window_in[r][0] = window_ff[r][1];
         window_in[r][1] = window_ff[r][2];
      end
      window_in[0][2] = upper_rd_ff;
      window_in[1][2] = lower_rd_ff;
      window_in[2][2] = s1_req_ff.pixel;

      centre = window_in[1][1];
      nb[0]  = window_in[0][0];
      nb[1]  = window_in[0][1];
      nb[2]  = window_in[0][2];
      nb[3]  = window_in[1][2];
      nb[4]  = window_in[2][2];
      nb[5]  = window_in[2][1];
      nb[6]  = window_in[2][0];
      nb[7]  = window_in[1][0];
      for (int i = 0; i < CODE_W; i++) begin
         code[i] = (nb[i] >= centre);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || s1_clear) begin
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               window_ff[r][k] <= '0;
            end
         end
      end else if (s1_write) begin
         window_ff <= window_in;
      end
   end

   always_comb begin
      stage.valid = s1_valid_ff;
      stage.kind  = s1_req_ff.req_type;
      stage.hit   = s1_write && s1_interior_ff;
      stage.code  = code;
      stage.bin   = s1_req_ff.bin;
   end

endmodule

// ===== rtl/lbph_counters.sv =====
`timescale 1ns / 1ps
`include "lbp_histogram_3x3_assert.svh"

module lbph_counters (
   input  logic                     clock,
   input  logic                     reset,
   input  lbph_pkg::lbph_stage_type stage,
   output logic                     push,
   output lbph_pkg::lbph_rsp_type   push_data
);
   import lbph_pkg::*;

   logic               s2_valid_ff;
   logic [1:0]         s2_kind_ff;
   logic               s2_hit_ff;
   logic [CODE_W-1:0]  s2_code_ff;
   logic [BIN_W-1:0]   s2_addr_ff;
   logic [BIN_W-1:0]   rd_addr;

   logic [COUNT_W-1:0] count_mem [NUM_BINS];
   logic [COUNT_W-1:0] count_rd_ff;
   logic [NUM_BINS-1:0] valid_bits_ff;

   logic               last_en_ff;
   logic [BIN_W-1:0]   last_addr_ff;
   logic [COUNT_W-1:0] last_data_ff;

   logic [COUNT_W-1:0] value;
   logic [COUNT_W-1:0] count_inc;
   logic               wr_en;
   logic               s2_clear;

   assign rd_addr = stage.hit ? BIN_W'(stage.code) : stage.bin;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      s2_kind_ff <= stage.kind;
      s2_hit_ff  <= stage.hit;
      s2_code_ff <= stage.code;
      s2_addr_ff <= rd_addr;
   end

   always_ff @(posedge clock) begin
      count_rd_ff <= count_mem[rd_addr];
      if (wr_en) begin
         count_mem[s2_addr_ff] <= count_inc;
      end
   end

   // The read above misses a write to the same bin at the same edge; that
   // write is held in a register so it can be forwarded.
   always_comb begin
      if (last_en_ff && (last_addr_ff == s2_addr_ff)) begin
         value = last_data_ff;
      end else if (valid_bits_ff[s2_addr_ff]) begin
         value = count_rd_ff;
      end else begin
         value = '0;
      end
      count_inc = (value == COUNT_MAX) ? value : value + COUNT_W'(1);
   end

   assign wr_en    = s2_valid_ff && s2_hit_ff;
   assign s2_clear = s2_valid_ff && (s2_kind_ff == REQ_CLEAR);

   always_ff @(posedge clock) begin
      if (reset || s2_clear) begin
         valid_bits_ff <= '0;
      end else if (wr_en) begin
         valid_bits_ff[s2_addr_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_en_ff <= 1'b0;
      end else begin
         last_en_ff <= wr_en;
      end
   end

   always_ff @(posedge clock) begin
      last_addr_ff <= s2_addr_ff;
      last_data_ff <= count_inc;
   end

   assign push = s2_valid_ff;

   always_comb begin
      push_data.code_valid = wr_en;
      push_data.lbp_code   = wr_en ? s2_code_ff : '0;
      push_data.bin_count  = (s2_kind_ff == REQ_READ) ? value : '0;
   end

   `LBPH_ASSERT(a_clear_wipes_bins, clock, reset, s2_clear |=> (valid_bits_ff == '0))
   `LBPH_ASSERT(a_write_marks_bin, clock, reset, wr_en |=> valid_bits_ff[$past(s2_addr_ff)])

endmodule

// ===== rtl/lbph_rsp_queue.sv =====
`timescale 1ns / 1ps

module lbph_rsp_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  lbph_pkg::lbph_rsp_type         push_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output lbph_pkg::lbph_rsp_type         rsp_data,
   output logic [lbph_pkg::RSP_LVL_W-1:0] level
);
   import lbph_pkg::*;

   lbph_rsp_type         entries_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [RSP_LVL_W-1:0] level_ff, level_in;
   logic                 pop;

   assign rsp_valid = (level_ff != '0);
   assign rsp_data  = entries_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign level     = level_ff;

   always_comb begin
      case ({push, pop})
         2'b10:   level_in = level_ff + RSP_LVL_W'(1);
         2'b01:   level_in = level_ff - RSP_LVL_W'(1);
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         level_ff <= level_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + RSP_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + RSP_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/lbp_histogram_3x3.sv =====
`timescale 1ns / 1ps
`include "lbp_histogram_3x3_assert.svh"
// A request beat accepted at one clock edge passes the window step and the counter step,
// is then written into the result queue and can leave on rsp the cycle after that write.
// Throughput: one request beat per cycle, limited only by the four-entry result queue.
// Reset (synchronous, active high) clears positions, window, bin valid bits and the queue;
// the line stores are not cleared, so no start-up sweep is needed.
module lbp_histogram_3x3 #(
   parameter int MAX_COLS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  lbph_pkg::lbph_req_type            req_data,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output lbph_pkg::lbph_rsp_type            rsp_data,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lbph_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lbph_pkg::CFG_W-1:0]        csr_data
);
   import lbph_pkg::*;

   localparam int USED_W = RSP_LVL_W + 1;

   // The block is a three-step pipeline with no stalls inside it:
   //   accept edge:  request captured, line stores read at the current column,
   //                 raster position advanced.
   //   window step:  the 3x3 window shifts in the new column, the eight
   //                 neighbor compares form the code, the line stores are written
   //                 back, and the bin counter memory is read at the code (interior pixel)
   //                 or at the requested bin (any other beat).
   //   counter step: the count is formed with forwarding from the previous
   //                 write, incremented with saturation and written back, and
   //                 the result beat is pushed into the result queue.
   // Because nothing inside the pipeline can stall, req_ready is a credit
   // check: beats in flight plus beats queued must leave room in the queue.

   logic             csr_accept;
   logic             csr_known;
   logic [CFG_W-1:0] image_cols_ff, image_rows_ff;
   lbph_cfg_type     cfg;

   logic             req_accept;
   lbph_stage_type   stage;
   logic             push;
   lbph_rsp_type     push_data;
   logic [RSP_LVL_W-1:0] level;
   logic [USED_W-1:0]    credit_used;

   // Configuration writes are taken at once; a write to a known register
   // also restarts the frame, while the histogram counts are kept.
   assign csr_ready  = !reset;
   assign csr_accept = csr_valid && csr_ready;
   assign csr_known  = (csr_index == CSR_IMAGE_COLS) || (csr_index == CSR_IMAGE_ROWS);

   always_ff @(posedge clock) begin
      if (reset) begin
         image_cols_ff <= DIM_RESET;
         image_rows_ff <= DIM_RESET;
      end else if (csr_accept) begin
         if (csr_index == CSR_IMAGE_COLS) begin
            image_cols_ff <= csr_data;
         end
         if (csr_index == CSR_IMAGE_ROWS) begin
            image_rows_ff <= csr_data;
         end
      end
   end

   always_comb begin
      cfg.restart    = csr_accept && csr_known;
      cfg.image_cols = image_cols_ff;
      cfg.image_rows = image_rows_ff;
   end

   // Every beat in the window step or the counter step owns one queue slot.
   assign credit_used = USED_W'(level) + USED_W'(stage.valid) + USED_W'(push);
   assign req_ready   = !reset && (credit_used < USED_W'(RSP_DEPTH));
   assign req_accept  = req_valid && req_ready;

   lbph_window #(
      .MAX_COLS (MAX_COLS)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_data   (req_data),
      .cfg        (cfg),
      .stage      (stage)
   );

   lbph_counters u_counters (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .push      (push),
      .push_data (push_data)
   );

   lbph_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .level     (level)
   );

   // The credit check must keep the queue from ever overflowing.
   `LBPH_ASSERT_NEVER(a_credit_bound, clock, reset, credit_used > USED_W'(RSP_DEPTH))
   // Every accepted request beat reaches the queue through the window step and the counter step.
   `LBPH_ASSERT(a_accept_reaches_queue, clock, reset, req_accept |-> ##2 push)

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import lbph_pkg::*;

   // Request kind with no meaning: the block must ignore it and answer with zeros.
   localparam logic [1:0] REQ_IGNORED = 2'd3;
   // A register index past the two real registers. Writes to it change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = CSR_IDX_W'(3);

   localparam int unsigned COLS_LIMIT   = 1024;
   localparam int unsigned BACKLOG_MAX  = 64;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned REPORT_LIMIT = 100;
   localparam int unsigned SUB_BEATS    = 170;

   logic         clock = 1'b0;
   logic         reset = 1'b1;

   logic         req_valid = 1'b0;
   logic         req_ready;
   lbph_req_type req_data = '0;

   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   lbph_rsp_type rsp_data;

   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_data = '0;

   // Request beats waiting for the driver, and results predicted for accepted beats.
   lbph_req_type req_backlog [$];
   lbph_rsp_type predicted_results [$];

   // Idle and stall odds in percent, set by the stimulus for each phase.
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   // The stimulus bumps hold_requests to ask for one long receiver hold-off;
   // the result side counts the hold-off out in its own process.
   int unsigned hold_requests = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left = 0;

   int unsigned mismatch_count = 0;

   // Predictor state: a private copy of the block's line stores, window,
   // scan position, histogram and configuration.
   bit [PIX_W-1:0]   upper_row [COLS_LIMIT];
   bit [PIX_W-1:0]   lower_row [COLS_LIMIT];
   bit [PIX_W-1:0]   win [3][3];
   int unsigned      col_pos = 0;
   int unsigned      row_pos = 0;
   bit [COUNT_W-1:0] hist [NUM_BINS];
   logic [CFG_W-1:0] cfg_cols = DIM_RESET;
   logic [CFG_W-1:0] cfg_rows = DIM_RESET;
   // Most recent code, so that random reads often hit a bin that is counting.
   logic [CODE_W-1:0] last_code = '0;

   lbp_histogram_3x3 dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // Out-of-range register values saturate into the legal range.
   function automatic int unsigned clamp_dim(logic [CFG_W-1:0] value, int unsigned hi);
      if (value < MIN_DIM) return MIN_DIM;
      if (value > hi) return hi;
      return 32'(value);
   endfunction

   // A new frame starts at column 0 of row 0 with an empty window.
   // The line stores are left alone; the first two rows overwrite them.
   function automatic void restart_frame();
      col_pos = 0;
      row_pos = 0;
      win = '{default: '0};
   endfunction

   // Works out the single result beat that one accepted request beat causes
   // and advances the predictor state the same way the block does.
   function automatic lbph_rsp_type predict_lbph_result(lbph_req_type beat);
      lbph_rsp_type      res;
      int unsigned       cols;
      int unsigned       rows;
      int unsigned       c;
      logic [PIX_W-1:0]  centre;
      logic [PIX_W-1:0]  ring [8];
      logic [CODE_W-1:0] code;
      res = '0;
      cols = clamp_dim(cfg_cols, COLS_LIMIT);
      rows = clamp_dim(cfg_rows, ROW_LIMIT);
      case (beat.req_type)
         REQ_PIXEL: begin
            // A shrunken row length can leave the column past the new end.
            c = (col_pos >= cols) ? 0 : col_pos;
            for (int r = 0; r < 3; r++) begin
               win[r][0] = win[r][1];
               win[r][1] = win[r][2];
            end
            win[0][2] = upper_row[c];
            win[1][2] = lower_row[c];
            win[2][2] = beat.pixel;
            upper_row[c] = lower_row[c];
            lower_row[c] = beat.pixel;
            // Only a window whose centre is an interior pixel forms a code.
            if (row_pos >= 2 && c >= 2) begin
               centre = win[1][1];
               // Neighbors clockwise from the top-left; bit i for neighbor i.
               ring = '{win[0][0], win[0][1], win[0][2], win[1][2],
                        win[2][2], win[2][1], win[2][0], win[1][0]};
               for (int i = 0; i < 8; i++) code[i] = (ring[i] >= centre);
               if (hist[code] != COUNT_MAX) hist[code]++;
               res.code_valid = 1'b1;
               res.lbp_code = code;
               last_code = code;
            end
            if (c + 1 >= cols) begin
               col_pos = 0;
               row_pos = (row_pos + 1 >= rows) ? 0 : row_pos + 1;
            end else begin
               col_pos = c + 1;
            end
         end
         REQ_READ: begin
            res.bin_count = hist[beat.bin];
         end
         REQ_CLEAR: begin
            hist = '{default: '0};
            restart_frame();
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   function automatic void note_mismatch(string field, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $error("%s mismatch: expected %0h, actual %0h", field, want, got);
   endfunction

   // Request driver. A beat that is accepted gets its result predicted at the
   // same edge; the next beat, or an idle cycle, is then chosen at random.
   always @(posedge clock) begin : drive_requests
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            predicted_results.insert(predicted_results.size(), predict_lbph_result(req_data));
         if (!req_valid || req_ready) begin
            if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= req_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor. Every accepted result beat is checked field by field
   // against the oldest prediction. Ready is dropped at random, or for a long
   // stretch when a hold-off has been asked for.
   always @(posedge clock) begin : check_results
      lbph_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $error("result beat arrived with no request outstanding");
            end else begin
               want = predicted_results.pop_front();
               if (rsp_data.code_valid !== want.code_valid)
                  note_mismatch("code_valid", 32'(want.code_valid), 32'(rsp_data.code_valid));
               if (rsp_data.lbp_code !== want.lbp_code)
                  note_mismatch("lbp_code", 32'(want.lbp_code), 32'(rsp_data.lbp_code));
               if (rsp_data.bin_count !== want.bin_count)
                  note_mismatch("bin_count", 32'(want.bin_count), 32'(rsp_data.bin_count));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   // Queues one request beat, holding back while the backlog is full so that
   // long phases do not pile up in memory.
   task automatic send_beat(logic [1:0] kind, logic [PIX_W-1:0] px, logic [BIN_W-1:0] bin_idx);
      lbph_req_type beat;
      beat.req_type = kind;
      beat.pixel = px;
      beat.bin = bin_idx;
      while (req_backlog.size() >= BACKLOG_MAX) @(posedge clock);
      req_backlog.insert(req_backlog.size(), beat);
   endtask

   // Mostly pixels, with many ties so that the "at least the center" compare
   // sees equal values; reads often aim at the bin that was last counted.
   task automatic send_random_beat();
      int unsigned pick;
      logic [PIX_W-1:0] px;
      logic [BIN_W-1:0] bin_idx;
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 2))
         0: px = PIX_W'($urandom_range(0, 255));
         1: px = PIX_W'(120 + $urandom_range(0, 3));
         default: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      endcase
      bin_idx = $urandom_range(0, 1) ? last_code : BIN_W'($urandom_range(0, 255));
      if (pick < 82) send_beat(REQ_PIXEL, px, bin_idx);
      else if (pick < 92) send_beat(REQ_READ, px, bin_idx);
      else if (pick < 96) send_beat(REQ_CLEAR, px, bin_idx);
      else send_beat(REQ_IGNORED, px, bin_idx);
   endtask

   // The sender stops until every predicted result has come back, then a few
   // more cycles pass so that the block is quiet before a register write.
   task automatic wait_drained();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || predicted_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // One register write beat. Must be called at a rising edge.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_IMAGE_COLS) begin
         cfg_cols = value;
         restart_frame();
      end else if (idx == CSR_IMAGE_ROWS) begin
         cfg_rows = value;
         restart_frame();
      end
      @(posedge clock);
   endtask

   // Small frames keep codes frequent; now and then a size is out of range.
   task automatic write_random_size();
      logic [CFG_W-1:0] cols;
      logic [CFG_W-1:0] rows;
      case ($urandom_range(0, 15))
         0, 1: cols = CFG_W'($urandom_range(0, 2));
         2: cols = CFG_W'($urandom_range(1025, 2047));
         default: cols = CFG_W'($urandom_range(3, 10));
      endcase
      case ($urandom_range(0, 15))
         0, 1: rows = CFG_W'($urandom_range(0, 2));
         2: rows = CFG_W'($urandom_range(1025, 2047));
         default: rows = CFG_W'($urandom_range(3, 6));
      endcase
      write_csr(CSR_IMAGE_COLS, cols);
      write_csr(CSR_IMAGE_ROWS, rows);
   endtask

   initial begin : stimulus
      int unsigned send_pcts [4];
      int unsigned stall_pcts [4];
      send_pcts = '{0, 81, 0, 15};
      stall_pcts = '{0, 0, 81, 15};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Straight out of reset: empty bins, and the ignored request kind.
      send_beat(REQ_READ, 8'h00, 8'h00);
      send_beat(REQ_READ, 8'hFF, 8'hFF);
      send_beat(REQ_IGNORED, 8'hFF, 8'hFF);
      wait_drained();

      // Smallest frame, with the row count written below range so it clamps up.
      write_csr(CSR_IMAGE_COLS, 11'd3);
      write_csr(CSR_IMAGE_ROWS, 11'd0);
      // A cross of bright pixels around a mid-grey center.
      send_beat(REQ_PIXEL, 8'h00, 8'h00);
      send_beat(REQ_PIXEL, 8'hFF, 8'h00);
      send_beat(REQ_PIXEL, 8'h00, 8'h00);
      send_beat(REQ_PIXEL, 8'hFF, 8'h00);
      send_beat(REQ_PIXEL, 8'h80, 8'h00);
      wait_drained();
      // A write to an unused index must not restart the frame in progress.
      write_csr(CSR_SPARE, '1);
      send_beat(REQ_PIXEL, 8'hFF, 8'h00);
      send_beat(REQ_PIXEL, 8'h00, 8'h00);
      send_beat(REQ_PIXEL, 8'hFF, 8'h00);
      send_beat(REQ_PIXEL, 8'h00, 8'h00);
      // The frame wraps; an all-zero frame gives ties on every neighbor.
      repeat (9) send_beat(REQ_PIXEL, 8'h00, 8'hFF);
      send_beat(REQ_READ, 8'h00, 8'hFF);
      send_beat(REQ_READ, 8'h00, 8'hAA);
      send_beat(REQ_CLEAR, 8'h00, 8'h00);
      send_beat(REQ_READ, 8'h00, 8'hAA);
      wait_drained();

      // The row count is written above range to check the upper clamp; a few
      // short rows of one flat grey level send every code into the same bin.
      write_csr(CSR_IMAGE_COLS, 11'd5);
      write_csr(CSR_IMAGE_ROWS, '1);
      send_beat(REQ_CLEAR, 8'h00, 8'h00);
      repeat (20) send_beat(REQ_PIXEL, 8'h5A, 8'h00);
      send_beat(REQ_READ, 8'h00, 8'hFF);
      wait_drained();

      // Random traffic under each idling pattern, two frame sizes per pattern.
      for (int m = 0; m < 4; m++) begin
         send_idle_pct = send_pcts[m];
         rsp_stall_pct = stall_pcts[m];
         for (int s = 0; s < 2; s++) begin
            write_random_size();
            repeat (SUB_BEATS) send_random_beat();
            wait_drained();
         end
      end

      // Back-pressure: the receiver holds off for a long stretch while the
      // sender keeps offering beats, so the result queue fills and the block
      // stops taking requests.
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      write_random_size();
      hold_requests++;
      repeat (150) send_random_beat();
      wait_drained();

      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   // Ends the run as failed if the stimulus has not finished in time.
   initial begin : watchdog
      #1_000_000;
      $display("testbench failed");
      $finish;
   end

endmodule
